// File: hdl/che_pkg.sv
// ----------------------------------------------------------------------------
// che_pkg: shared types and constants
// Command and result payloads, kind codes, register indexes and widths for
// the clamped histogram engine.
// ----------------------------------------------------------------------------
`default_nettype none

package che_pkg;

	localparam int NUM_BINS = 64;
	localparam int BIN_W    = 6;
	localparam int USED_W   = 7;
	localparam int COUNT_W  = 32;
	localparam int VALUE_W  = 16;
	localparam int WIDE_W   = 18;

	localparam logic [1:0] KIND_ADD  = 2'd0;
	localparam logic [1:0] KIND_READ = 2'd1;
	localparam logic [1:0] KIND_DUMP = 2'd2;

	localparam logic REG_LOWEST  = 1'b0;
	localparam logic REG_HIGHEST = 1'b1;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef struct packed {
		logic [1:0]                kind;
		logic signed [VALUE_W-1:0] sample;
	} cmd_t;

	typedef struct packed {
		logic [BIN_W-1:0]   bin_index;
		logic [COUNT_W-1:0] bin_count;
		logic [COUNT_W-1:0] tallest;
		logic [COUNT_W-1:0] shortest;
		logic               out_of_range;
		logic               last;
	} result_t;

	typedef struct packed {
		logic shift;
		logic inc;
	} cell_ctrl_t;

	typedef struct packed {
		logic [BIN_W-1:0]  add_bin;
		logic [BIN_W-1:0]  read_bin;
		logic              read_oor;
		logic [USED_W-1:0] used;
	} decode_t;

endpackage

`default_nettype wire

// File: hdl/che_cell.sv
// ----------------------------------------------------------------------------
// che_cell: one bin counter of the histogram chain
// Holds a saturating count; increments on a hit or takes its neighbor's
// count while the chain rotates for a dump.
// ----------------------------------------------------------------------------
`default_nettype none

module che_cell (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire che_pkg::cell_ctrl_t          ctrl,
	input  wire logic [che_pkg::COUNT_W-1:0]  neighbor,
	output logic      [che_pkg::COUNT_W-1:0]  count
);

	logic [che_pkg::COUNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.shift) begin
			count_q <= neighbor;
		end else if (ctrl.inc && count_q != che_pkg::COUNT_MAX) begin
			count_q <= count_q + che_pkg::COUNT_W'(1);
		end
	end

	assign count = count_q;

endmodule

`default_nettype wire

// File: hdl/che_decode.sv
// ----------------------------------------------------------------------------
// che_decode: sample to bin mapping
// Works out the bins in use from the configured bounds, the clamped bin of
// an added sample and the bin and range flag of a read.
// ----------------------------------------------------------------------------
`default_nettype none

module che_decode (
	input  wire logic signed [che_pkg::VALUE_W-1:0] sample,
	input  wire logic signed [che_pkg::VALUE_W-1:0] lowest,
	input  wire logic signed [che_pkg::VALUE_W-1:0] highest,
	output che_pkg::decode_t                        dec
);

	logic signed [che_pkg::WIDE_W-1:0] s_w;
	logic signed [che_pkg::WIDE_W-1:0] lo_w;
	logic signed [che_pkg::WIDE_W-1:0] hi_w;
	logic signed [che_pkg::WIDE_W-1:0] span;
	logic signed [che_pkg::WIDE_W-1:0] top;
	logic signed [che_pkg::WIDE_W-1:0] offs;
	logic [che_pkg::USED_W-1:0]        used;

	always_comb begin
		s_w  = che_pkg::WIDE_W'(sample);
		lo_w = che_pkg::WIDE_W'(lowest);
		hi_w = che_pkg::WIDE_W'(highest);
		span = hi_w - lo_w + che_pkg::WIDE_W'(1);
		if (span < che_pkg::WIDE_W'(1)) begin
			used = che_pkg::USED_W'(1);
		end else if (span > che_pkg::WIDE_W'(che_pkg::NUM_BINS)) begin
			used = che_pkg::USED_W'(che_pkg::NUM_BINS);
		end else begin
			used = span[che_pkg::USED_W-1:0];
		end
		top  = lo_w + signed'({{(che_pkg::WIDE_W-che_pkg::USED_W){1'b0}}, used})
			- che_pkg::WIDE_W'(1);
		offs = s_w - lo_w;

		dec.used = used;
		if (s_w <= lo_w) begin
			dec.add_bin = '0;
		end else if (s_w >= top) begin
			dec.add_bin = che_pkg::BIN_W'(used - che_pkg::USED_W'(1));
		end else begin
			dec.add_bin = offs[che_pkg::BIN_W-1:0];
		end
		dec.read_oor = (s_w < lo_w) || (s_w > top);
		dec.read_bin = dec.read_oor ? '0 : offs[che_pkg::BIN_W-1:0];
	end

endmodule

`default_nettype wire

// File: hdl/clamped_histogram_engine_unit.sv
// ----------------------------------------------------------------------------
// clamped_histogram_engine_unit: histogram with clamped end bins
// Add and read commands may be issued every cycle while no dump is busy;
// each result passes the command stage and the result register.
// A dump rotates the cell chain once around while busy is high, giving
// one result per bin in use through the result register.
// Reset clears every bin counter at once and sets the bounds to 0 and 63.
// ----------------------------------------------------------------------------
`default_nettype none

module clamped_histogram_engine_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire che_pkg::cmd_t                  cmd,
	output logic                                valid,
	output che_pkg::result_t                    result,
	input  wire logic                           cfg_we,
	input  wire logic                           cfg_index,
	input  wire logic [che_pkg::VALUE_W-1:0]    cfg_data
);

	logic signed [che_pkg::VALUE_W-1:0] lowest_q;
	logic signed [che_pkg::VALUE_W-1:0] highest_q;

	che_pkg::decode_t dec;

	logic                        op_valid_s1;
	logic [1:0]                  kind_s1;
	logic [che_pkg::BIN_W-1:0]   bin_s1;
	logic                        oor_s1;

	logic                        dump_q;
	logic [che_pkg::BIN_W-1:0]   step_q;
	logic [che_pkg::USED_W-1:0]  used_q;
	logic [che_pkg::COUNT_W-1:0] hi_q;
	logic [che_pkg::COUNT_W-1:0] lo_q;

	logic                        valid_q;
	che_pkg::result_t            result_q;

	logic [che_pkg::COUNT_W-1:0] counts [che_pkg::NUM_BINS];
	logic [che_pkg::COUNT_W-1:0] sel_count;
	logic [che_pkg::COUNT_W-1:0] inc_count;
	logic [che_pkg::COUNT_W-1:0] head;
	logic [che_pkg::COUNT_W-1:0] hi_next;
	logic [che_pkg::COUNT_W-1:0] lo_next;
	logic                        accept;
	logic                        emit;
	logic                        fin;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lowest_q  <= '0;
			highest_q <= che_pkg::VALUE_W'(63);
		end else if (cfg_we) begin
			case (cfg_index)
				che_pkg::REG_LOWEST:  lowest_q  <= cfg_data;
				che_pkg::REG_HIGHEST: highest_q <= cfg_data;
				default: ;
			endcase
		end
	end

	che_decode u_decode (
		.sample  (cmd.sample),
		.lowest  (lowest_q),
		.highest (highest_q),
		.dec     (dec)
	);

	assign accept = start && !dump_q;
	assign busy   = dump_q;

	// command stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_valid_s1 <= 1'b0;
		end else begin
			op_valid_s1 <= accept && (cmd.kind == che_pkg::KIND_ADD ||
				cmd.kind == che_pkg::KIND_READ);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= cmd.kind;
			bin_s1  <= (cmd.kind == che_pkg::KIND_ADD) ? dec.add_bin : dec.read_bin;
			oor_s1  <= (cmd.kind == che_pkg::KIND_READ) && dec.read_oor;
		end
	end

	// chain of bin cells, rotating toward cell 0 during a dump
	for (genvar i = 0; i < che_pkg::NUM_BINS; i++) begin : g_cell
		che_pkg::cell_ctrl_t ctrl;
		assign ctrl.shift = dump_q;
		assign ctrl.inc   = op_valid_s1 && kind_s1 == che_pkg::KIND_ADD &&
			bin_s1 == che_pkg::BIN_W'(i);
		che_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.neighbor (counts[(i + 1) % che_pkg::NUM_BINS]),
			.count    (counts[i])
		);
	end

	assign sel_count = counts[bin_s1];
	assign inc_count = (sel_count == che_pkg::COUNT_MAX) ? sel_count
		: sel_count + che_pkg::COUNT_W'(1);
	assign head      = counts[0];

	// dump sequencing
	assign emit    = dump_q && ({1'b0, step_q} < used_q);
	assign fin     = dump_q && ({1'b0, step_q} == used_q - che_pkg::USED_W'(1));
	assign hi_next = (step_q == '0 || head > hi_q) ? head : hi_q;
	assign lo_next = (step_q == '0 || head < lo_q) ? head : lo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dump_q <= 1'b0;
			step_q <= '0;
		end else if (dump_q) begin
			step_q <= step_q + che_pkg::BIN_W'(1);
			if (step_q == che_pkg::BIN_W'(che_pkg::NUM_BINS - 1)) begin
				dump_q <= 1'b0;
			end
		end else if (accept && cmd.kind == che_pkg::KIND_DUMP) begin
			dump_q <= 1'b1;
			step_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && cmd.kind == che_pkg::KIND_DUMP) begin
			used_q <= dec.used;
		end
		if (dump_q) begin
			hi_q <= hi_next;
			lo_q <= lo_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= op_valid_s1 || emit;
		end
	end

	always_ff @(posedge clk) begin
		if (op_valid_s1) begin
			result_q.bin_index    <= bin_s1;
			result_q.tallest      <= '0;
			result_q.shortest     <= '0;
			result_q.out_of_range <= oor_s1;
			result_q.last         <= 1'b1;
			if (kind_s1 == che_pkg::KIND_ADD) begin
				result_q.bin_count <= inc_count;
			end else if (oor_s1) begin
				result_q.bin_count <= '0;
			end else begin
				result_q.bin_count <= sel_count;
			end
		end else if (emit) begin
			result_q.bin_index    <= step_q;
			result_q.bin_count    <= head;
			result_q.tallest      <= fin ? hi_next : '0;
			result_q.shortest     <= fin ? lo_next : '0;
			result_q.out_of_range <= 1'b0;
			result_q.last         <= fin;
		end
	end

	assign valid  = valid_q;
	assign result = result_q;

	// no add or read is in flight while the chain rotates
	a_dump_excl: assert property (@(posedge clk) disable iff (!arst_n)
		dump_q |-> !op_valid_s1)
		else $error("command stage active during dump");

	// a dump ends after one full rotation
	a_dump_len: assert property (@(posedge clk) disable iff (!arst_n)
		dump_q && step_q == che_pkg::BIN_W'(che_pkg::NUM_BINS - 1) |=> !dump_q)
		else $error("dump did not end after full rotation");

	// range flag only on a single read result
	a_oor_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && result.out_of_range |-> result.last && result.bin_count == '0)
		else $error("out of range flag on unexpected result");

	// extremes are ordered on every final result
	a_extremes: assert property (@(posedge clk) disable iff (!arst_n)
		valid && result.last |-> result.tallest >= result.shortest)
		else $error("tallest below shortest");

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: clamped histogram engine unit
// Drives add, read and dump commands under several bin bound settings, keeps
// its own copy of the bin counters and checks each result transfer field by
// field against the oldest predicted result.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	import che_pkg::*;

	typedef struct {
		cmd_t c;
		bit   drain;
	} cmd_item_t;

	logic                clk;
	logic                arst_n    = 1'b0;
	logic                start     = 1'b0;
	logic                busy;
	cmd_t                cmd       = '0;
	logic                valid;
	result_t             result;
	logic                cfg_we    = 1'b0;
	logic                cfg_index = REG_LOWEST;
	logic [VALUE_W-1:0]  cfg_data  = '0;

	clamped_histogram_engine_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.valid     (valid),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// own copy of the bounds and counters
	logic signed [VALUE_W-1:0] lowest_q  = 16'sd0;
	logic signed [VALUE_W-1:0] highest_q = 16'sd63;
	logic [COUNT_W-1:0]        bin_q [NUM_BINS];

	cmd_item_t pending_cmds [$];
	result_t   expected_results [$];

	int idle_pct     = 31;
	int errors       = 0;
	int results_seen = 0;
	int n_adds       = 0;
	int n_reads      = 0;
	int n_dumps      = 0;
	int n_ignored    = 0;
	int n_settings   = 1;
	logic [VALUE_W-1:0] last_sample = '0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		for (int i = 0; i < NUM_BINS; i++)
			bin_q[i] = '0;
	end

	function automatic int bins_in_use();
		int n;
		n = int'(highest_q) - int'(lowest_q) + 1;
		if (n < 1)
			n = 1;
		if (n > NUM_BINS)
			n = NUM_BINS;
		return n;
	endfunction

	task automatic apply_command(input cmd_t c);
		int                 used;
		int                 top;
		int                 lo_v;
		int                 s;
		int                 b;
		logic [COUNT_W-1:0] hi;
		logic [COUNT_W-1:0] lo;
		result_t            r;
		used = bins_in_use();
		lo_v = lowest_q;
		top  = lo_v + used - 1;
		s    = $signed(c.sample);
		r    = '0;
		case (c.kind)
			KIND_ADD: begin
				n_adds++;
				if (s <= lo_v)
					b = 0;
				else if (s >= top)
					b = used - 1;
				else
					b = s - lo_v;
				if (bin_q[b] != COUNT_MAX)
					bin_q[b] = bin_q[b] + 1;
				r.bin_index = b[BIN_W-1:0];
				r.bin_count = bin_q[b];
				r.last      = 1'b1;
				expected_results.push_back(r);
			end
			KIND_READ: begin
				n_reads++;
				if (s < lo_v || s > top) begin
					r.out_of_range = 1'b1;
				end else begin
					b = s - lo_v;
					r.bin_index = b[BIN_W-1:0];
					r.bin_count = bin_q[b];
				end
				r.last = 1'b1;
				expected_results.push_back(r);
			end
			KIND_DUMP: begin
				n_dumps++;
				hi = bin_q[0];
				lo = bin_q[0];
				for (int i = 0; i < used; i++) begin
					if (bin_q[i] > hi)
						hi = bin_q[i];
					if (bin_q[i] < lo)
						lo = bin_q[i];
				end
				for (int i = 0; i < used; i++) begin
					r           = '0;
					r.bin_index = i[BIN_W-1:0];
					r.bin_count = bin_q[i];
					if (i == used - 1) begin
						r.tallest  = hi;
						r.shortest = lo;
						r.last     = 1'b1;
					end
					expected_results.push_back(r);
				end
			end
			default: begin
				n_ignored++;
			end
		endcase
	endtask

	// driver: start stays high until the transfer
	always @(posedge clk or negedge arst_n) begin
		cmd_item_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
			cmd   <= '0;
		end else begin
			if (start && !busy)
				apply_command(cmd);
			if (!start || !busy) begin
				if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct &&
				    (!pending_cmds[0].drain || expected_results.size() == 0)) begin
					nxt = pending_cmds.pop_front();
					start <= 1'b1;
					cmd   <= nxt.c;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: every result transfer against the oldest prediction
	always @(posedge clk) begin
		result_t want;
		if (arst_n && valid) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				$error("result transfer with nothing expected: bin_index %0d",
				       result.bin_index);
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (result.bin_index !== want.bin_index) begin
					$error("bin_index expected %0d got %0d", want.bin_index, result.bin_index);
					errors++;
				end
				if (result.bin_count !== want.bin_count) begin
					$error("bin_count expected %0d got %0d", want.bin_count, result.bin_count);
					errors++;
				end
				if (result.tallest !== want.tallest) begin
					$error("tallest expected %0d got %0d", want.tallest, result.tallest);
					errors++;
				end
				if (result.shortest !== want.shortest) begin
					$error("shortest expected %0d got %0d", want.shortest, result.shortest);
					errors++;
				end
				if (result.out_of_range !== want.out_of_range) begin
					$error("out_of_range expected %0b got %0b", want.out_of_range,
					       result.out_of_range);
					errors++;
				end
				if (result.last !== want.last) begin
					$error("last expected %0b got %0b", want.last, result.last);
					errors++;
				end
			end
		end
	end

	task automatic queue_cmd(input logic [1:0] kind, input int sample, input bit drain);
		cmd_item_t it;
		it.c.kind   = kind;
		it.c.sample = 16'(sample);
		it.drain    = drain;
		pending_cmds.push_back(it);
	endtask

	function automatic logic [VALUE_W-1:0] pick_sample();
		int lo_v;
		int top_v;
		int v;
		lo_v  = lowest_q;
		top_v = lo_v + bins_in_use() - 1;
		case ($urandom_range(9))
			0: v = -32768;
			1: v = 32767;
			2, 3: return 16'($urandom());
			default: v = lo_v - 3 + int'($urandom_range(top_v - lo_v + 6));
		endcase
		if (v < -32768)
			v = -32768;
		if (v > 32767)
			v = 32767;
		return 16'(v);
	endfunction

	task automatic queue_random(input int n);
		int                 r;
		logic [VALUE_W-1:0] s;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			// repeated adds on one bin back to back
			if (r < 62 && $urandom_range(99) < 30)
				s = last_sample;
			else
				s = pick_sample();
			last_sample = s;
			if (r < 62)
				queue_cmd(KIND_ADD, int'(s), 1'b0);
			else if (r < 85)
				queue_cmd(KIND_READ, int'(s), 1'b0);
			else if (r < 95)
				queue_cmd(KIND_DUMP, int'(s), 1'b0);
			else
				queue_cmd(2'd3, int'(s), 1'b0);
		end
	endtask

	task automatic wait_idle();
		do
			@(posedge clk);
		while (pending_cmds.size() != 0 || expected_results.size() != 0 || start || busy);
		repeat (8) @(posedge clk);
	endtask

	// leaves the write enable high; the caller drops it after the last write
	task automatic write_reg(input logic idx, input logic [VALUE_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		if (idx == REG_LOWEST)
			lowest_q = val;
		else
			highest_q = val;
		@(posedge clk);
	endtask

	int lows  [7] = '{0, -32768, 32767, -5, -7, 32700, 0};
	int highs [7] = '{63, 32767, -32768, 4, -7, 32767, 63};

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < 7; p++) begin
			if (p > 0) begin
				wait_idle();
				@(posedge clk);
				write_reg(REG_LOWEST, 16'(lows[p]));
				write_reg(REG_HIGHEST, 16'(highs[p]));
				cfg_we <= 1'b0;
				n_settings++;
			end
			idle_pct = (p < 3) ? 31 : (p < 5) ? 84 : 0;
			if (p == 0) begin
				queue_cmd(KIND_ADD, -32768, 1'b0);
				queue_cmd(KIND_ADD, 32767, 1'b0);
				queue_cmd(KIND_ADD, 0, 1'b0);
				queue_cmd(KIND_ADD, 63, 1'b0);
				queue_cmd(KIND_ADD, 64, 1'b0);
				queue_cmd(KIND_ADD, -1, 1'b0);
				queue_cmd(KIND_ADD, 5, 1'b0);
				queue_cmd(KIND_ADD, 5, 1'b0);
				queue_cmd(KIND_ADD, 5, 1'b0);
				queue_cmd(KIND_READ, 5, 1'b0);
				queue_cmd(KIND_READ, 0, 1'b0);
				queue_cmd(KIND_READ, 63, 1'b0);
				queue_cmd(KIND_READ, 64, 1'b0);
				queue_cmd(KIND_READ, -1, 1'b0);
				queue_cmd(KIND_READ, -32768, 1'b0);
				queue_cmd(KIND_READ, 32767, 1'b0);
				queue_cmd(2'd3, -32768, 1'b0);
				queue_cmd(KIND_DUMP, 0, 1'b0);
				queue_cmd(KIND_ADD, 5, 1'b0);
				queue_cmd(KIND_READ, 5, 1'b0);
			end
			if (p == 1) begin
				queue_random(10);
				// hold off until every result is back
				queue_cmd(KIND_READ, int'(pick_sample()), 1'b1);
				queue_random(10);
			end else begin
				queue_random(20);
			end
			queue_cmd(KIND_DUMP, 0, 1'b0);
		end
		wait_idle();
		$display("covered %0d adds, %0d reads, %0d dumps, %0d ignored commands,",
		         n_adds, n_reads, n_dumps, n_ignored);
		$display("%0d bound settings, %0d result transfers checked, %0d mismatches",
		         n_settings, results_seen, errors);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#3ms;
		$display("timeout with %0d results outstanding", expected_results.size());
		$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire

// File: sim.f
hdl/che_pkg.sv
hdl/che_cell.sv
hdl/che_decode.sv
hdl/clamped_histogram_engine_unit.sv
tb/sv/testbench.sv
